// File: hdl/plc_pkg.sv
// Shared types, character codes, event codes and command/status bundles for the lock controller.
`default_nettype none

package plc_pkg;

    // Input word: one keypad symbol or one link byte.
    typedef struct packed {
        logic       kind;
        logic [7:0] symbol;
    } in_word_t;

    // Result word: one per accepted input word.
    typedef struct packed {
        logic       door_open;
        logic [2:0] event_res;
        logic [7:0] echo_char;
        logic       entry_wrapped;
        logic [3:0] digits_entered;
    } out_word_t;

    localparam logic KIND_KEYPAD = 1'b0;
    localparam logic KIND_LINK   = 1'b1;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_Y    = 8'h59;
    localparam logic [7:0] CH_N    = 8'h4E;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_DIGIT   = 3'd1;
    localparam logic [2:0] EV_UNLOCK  = 3'd2;
    localparam logic [2:0] EV_WRONG   = 3'd3;
    localparam logic [2:0] EV_CANCEL  = 3'd4;
    localparam logic [2:0] EV_KEYCHG  = 3'd5;
    localparam logic [2:0] EV_REMCHG  = 3'd6;
    localparam logic [2:0] EV_REFUSED = 3'd7;

    // Class of work an input word needs.
    localparam logic [1:0] OP_SIMPLE = 2'd0;
    localparam logic [1:0] OP_UNLOCK = 2'd1;
    localparam logic [1:0] OP_KEYCHG = 2'd2;
    localparam logic [1:0] OP_REMOTE = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
        logic cmp_start;
        logic cpy_start;
        logic step;
        logic cmp_done;
        logic cpy_done;
        logic out_load;
    } plc_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       cmp_end;
        logic       cmp_match;
        logic       cpy_end;
    } plc_status_t;

endpackage

`default_nettype wire

// File: hdl/plc_ctrl.sv
// Sequencer for the lock controller: accepts a word, steps compare and copy walks, hands off results.
`default_nettype none

module plc_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire                  out_stall,
    input  plc_pkg::plc_status_t status,
    output plc_pkg::plc_cmd_t    cmd
);
    import plc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_CPY  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (status.op)
                    OP_SIMPLE:
                    begin
                        cmd.exec   = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_KEYCHG:
                    begin
                        cmd.cpy_start = 1'b1;
                        state_next    = S_CPY;
                    end
                    default:
                    begin
                        cmd.cmp_start = 1'b1;
                        state_next    = S_CMP;
                    end
                endcase
            end
            S_CMP:
            begin
                if (status.cmp_end)
                begin
                    cmd.cmp_done = 1'b1;
                    // A remote frame whose old password matched goes on to copy the new one.
                    if (status.op == OP_REMOTE && status.cmp_match)
                    begin
                        cmd.cpy_start = 1'b1;
                        state_next    = S_CPY;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_CPY:
            begin
                if (status.cpy_end)
                begin
                    cmd.cpy_done = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> $past(state_reg) == S_IDLE && $past(in_valid))
        else $error("decode stage entered without an accepted word");

    a_new_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside the hand-off state");

    a_held_result_blocks_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_valid_reg && out_stall |=> state_reg == S_DONE)
        else $error("result handed off over a stalled one");
`endif

endmodule

`default_nettype wire

// File: hdl/plc_datapath.sv
// Datapath of the lock controller: password and entry stores, link frame buffers, compare and copy walk.
`default_nettype none

module plc_datapath #(
    parameter int MAX_DIGITS = 10
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  plc_pkg::in_word_t    in_word,
    input  plc_pkg::plc_cmd_t    cmd,
    output plc_pkg::plc_status_t status,
    output plc_pkg::out_word_t   out_word
);
    import plc_pkg::*;

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int IW = $clog2(MAX_DIGITS);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DIGITS);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_OLD  = 2'd1;
    localparam logic [1:0] PH_NEW  = 2'd2;

    // Control state.
    logic          lock_open_reg;
    logic [CW-1:0] pw_len_reg;
    logic [CW-1:0] entry_count_reg;
    logic [CW-1:0] old_count_reg;
    logic [CW-1:0] new_count_reg;
    logic [1:0]    link_phase_reg;
    logic [CW-1:0] idx_reg;
    logic [1:0]    op_reg;
    logic [7:0]    pw_reg [MAX_DIGITS];

    // Payload state.
    logic [7:0]    entry_reg [MAX_DIGITS];
    logic [7:0]    old_reg [MAX_DIGITS];
    logic [7:0]    new_reg [MAX_DIGITS];
    in_word_t      item_reg;
    logic          copy_reg;
    logic [2:0]    event_reg;
    logic [7:0]    echo_reg;
    logic          wrap_reg;
    out_word_t     out_reg;

    logic [1:0]    op_in;
    logic          is_digit;
    logic          entry_full;
    logic          remote;
    logic [CW-1:0] cmp_len;
    logic [CW-1:0] cpy_len;
    logic [IW-1:0] ix;
    logic [7:0]    src_byte;
    logic          len_eq;
    logic          at_end;
    logic          cmp_match;
    logic [IW-1:0] ent_wa;
    logic          ent_we;
    logic          old_we;
    logic          new_we;
    logic [CW+3:0] count_ext;

    // Classify the incoming word against the state it will see.
    always_comb
    begin
        if (in_word.kind == KIND_KEYPAD && in_word.symbol == CH_Y)
            op_in = lock_open_reg ? OP_KEYCHG : OP_UNLOCK;
        else if (in_word.kind == KIND_LINK && link_phase_reg == PH_NEW && in_word.symbol == CH_E)
            op_in = OP_REMOTE;
        else
            op_in = OP_SIMPLE;
    end

    assign is_digit   = (item_reg.symbol >= CH_ZERO) && (item_reg.symbol <= CH_NINE);
    assign entry_full = (entry_count_reg >= MAX_CNT);
    assign remote     = (op_reg == OP_REMOTE);
    assign cmp_len    = remote ? old_count_reg : entry_count_reg;
    assign cpy_len    = remote ? new_count_reg : entry_count_reg;
    assign ix         = idx_reg[IW-1:0];
    assign src_byte   = remote ? (copy_reg ? new_reg[ix] : old_reg[ix]) : entry_reg[ix];
    assign len_eq     = (cmp_len == pw_len_reg);
    assign at_end     = (idx_reg == cmp_len);
    assign cmp_match  = len_eq && at_end;

    assign status.op        = op_reg;
    assign status.cmp_match = cmp_match;
    assign status.cmp_end   = !len_eq || at_end || (src_byte != pw_reg[ix]);
    assign status.cpy_end   = (idx_reg == pw_len_reg);

    // Store write decode for simple words, written on exec.
    always_comb
    begin
        ent_we = cmd.exec && item_reg.kind == KIND_KEYPAD && is_digit;
        ent_wa = entry_full ? '0 : entry_count_reg[IW-1:0];
        old_we = cmd.exec && item_reg.kind == KIND_LINK && link_phase_reg == PH_OLD
                 && item_reg.symbol != CH_E && item_reg.symbol != CH_R
                 && old_count_reg < MAX_CNT;
        new_we = cmd.exec && item_reg.kind == KIND_LINK && link_phase_reg == PH_NEW
                 && item_reg.symbol != CH_E && item_reg.symbol != CH_R
                 && new_count_reg < MAX_CNT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_open_reg   <= 1'b0;
            pw_len_reg      <= CW'(4);
            entry_count_reg <= '0;
            old_count_reg   <= '0;
            new_count_reg   <= '0;
            link_phase_reg  <= PH_IDLE;
            idx_reg         <= '0;
            op_reg          <= OP_SIMPLE;
            for (int i = 0; i < MAX_DIGITS; i++)
                pw_reg[i] <= (i < 4) ? CH_ZERO : 8'd0;
        end
        else
        begin
            if (cmd.load)
                op_reg <= op_in;

            if (cmd.exec)
            begin
                if (item_reg.kind == KIND_KEYPAD)
                begin
                    if (item_reg.symbol == CH_N)
                    begin
                        lock_open_reg   <= 1'b0;
                        entry_count_reg <= '0;
                    end
                    else if (is_digit)
                    begin
                        entry_count_reg <= CW'(ent_wa) + CW'(1);
                    end
                end
                else if (link_phase_reg == PH_OLD || link_phase_reg == PH_NEW)
                begin
                    if (item_reg.symbol == CH_E)
                        link_phase_reg <= PH_IDLE;
                    else if (item_reg.symbol == CH_R)
                        link_phase_reg <= (link_phase_reg == PH_OLD) ? PH_NEW : PH_IDLE;
                    else if (old_we)
                        old_count_reg <= old_count_reg + CW'(1);
                    else if (new_we)
                        new_count_reg <= new_count_reg + CW'(1);
                end
                else if (item_reg.symbol == CH_C)
                begin
                    link_phase_reg <= PH_OLD;
                    old_count_reg  <= '0;
                    new_count_reg  <= '0;
                end
                else
                begin
                    link_phase_reg <= PH_IDLE;
                end
            end

            if (cmd.cmp_start || cmd.cpy_start)
                idx_reg <= '0;
            else if (cmd.step)
                idx_reg <= idx_reg + CW'(1);

            if (cmd.cpy_start)
                pw_len_reg <= cpy_len;

            // The copy walk writes one password byte per step.
            if (cmd.step && copy_reg)
                pw_reg[ix] <= src_byte;

            if (cmd.cmp_done)
            begin
                if (remote)
                begin
                    link_phase_reg <= PH_IDLE;
                end
                else
                begin
                    entry_count_reg <= '0;
                    if (cmp_match)
                        lock_open_reg <= 1'b1;
                end
            end

            if (cmd.cpy_done && !remote)
            begin
                lock_open_reg   <= 1'b0;
                entry_count_reg <= '0;
            end
        end
    end

    assign count_ext = {4'd0, entry_count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg  <= in_word;
            event_reg <= EV_NONE;
            echo_reg  <= 8'd0;
            wrap_reg  <= 1'b0;
        end

        if (cmd.cmp_start)
            copy_reg <= 1'b0;
        else if (cmd.cpy_start)
            copy_reg <= 1'b1;

        if (ent_we)
            entry_reg[ent_wa] <= item_reg.symbol;
        if (old_we)
            old_reg[old_count_reg[IW-1:0]] <= item_reg.symbol;
        if (new_we)
            new_reg[new_count_reg[IW-1:0]] <= item_reg.symbol;

        if (cmd.exec)
        begin
            if (item_reg.kind == KIND_KEYPAD)
            begin
                if (item_reg.symbol == CH_N)
                begin
                    event_reg <= EV_CANCEL;
                end
                else if (is_digit)
                begin
                    event_reg <= EV_DIGIT;
                    echo_reg  <= item_reg.symbol;
                    wrap_reg  <= entry_full;
                end
            end
            else if ((link_phase_reg == PH_OLD || link_phase_reg == PH_NEW)
                     && item_reg.symbol == CH_E)
            begin
                // Only a frame still in its old-password part gets here.
                event_reg <= EV_REFUSED;
            end
        end

        if (cmd.cmp_done)
        begin
            if (remote)
                event_reg <= cmp_match ? EV_NONE : EV_REFUSED;
            else
                event_reg <= cmp_match ? EV_UNLOCK : EV_WRONG;
        end

        if (cmd.cpy_done)
            event_reg <= remote ? EV_REMCHG : EV_KEYCHG;

        if (cmd.out_load)
        begin
            out_reg.door_open      <= lock_open_reg;
            out_reg.event_res      <= event_reg;
            out_reg.echo_char      <= echo_reg;
            out_reg.entry_wrapped  <= wrap_reg;
            out_reg.digits_entered <= count_ext[3:0];
        end
    end

    assign out_word = out_reg;

`ifndef NO_ASSERTIONS
    a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= MAX_CNT && old_count_reg <= MAX_CNT && new_count_reg <= MAX_CNT)
        else $error("buffer count past capacity");

    a_pw_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pw_len_reg <= MAX_CNT)
        else $error("password length past capacity");

    a_copy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && copy_reg |-> idx_reg < pw_len_reg)
        else $error("copy walk wrote beyond the new password length");

    a_walk_ends_at_length: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && !copy_reg |-> idx_reg < cmp_len)
        else $error("compare walk stepped past the entry length");
`endif

endmodule

`default_nettype wire

// File: hdl/password_lock_controller.sv
// Top level of the keypad and serial-link door lock controller.
`default_nettype none

// Door lock controller. Each accepted input word (a keypad symbol or a link byte)
// gives exactly one result word carrying the lock state, an event code, the echoed
// digit, a wrap flag and the current digit count. A digit, a cancel or a link byte
// that does not finish a frame is accepted, executed and then handed off before the
// next word is accepted. Checking an entry walks the stored password one byte per
// cycle and stops at the first differing digit, at the end of the entry on a full
// match, or at once when the lengths differ. A keypad password change walks the
// entry instead, copying it into the password. A link frame closed by 'E' after
// 'R' compares its old password the same way and, on a match, copies the new one.
// A result that is not yet taken holds in the output register; the next word is
// accepted meanwhile and its result waits until the register is free.
module password_lock_controller #(
    parameter int MAX_DIGITS = 10
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  plc_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  wire                out_stall,
    output plc_pkg::out_word_t out_word
);
    import plc_pkg::*;

    plc_cmd_t    cmd;
    plc_status_t status;

    plc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    plc_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .cmd      (cmd),
        .status   (status),
        .out_word (out_word)
    );

endmodule

`default_nettype wire

// File: tb/password_lock_controller_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the password lock controller, with directed and random words.

module password_lock_controller_tb;
    import plc_pkg::*;

    localparam int DIGIT_CAP    = 10;
    localparam int SETTLE_WAIT  = 40;
    localparam int MAX_PRINTED  = 30;

    typedef enum logic [1:0] {LINK_IDLE, LINK_OLD, LINK_NEW} link_phase_t;
    typedef logic [DIGIT_CAP-1:0][7:0] digit_buf_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;

    // Lock state as the testbench expects it after every accepted word.
    logic        lock_open_q;
    digit_buf_t  password_q;
    int          password_len;
    digit_buf_t  entry_q;
    int          entry_len;
    link_phase_t frame_phase;
    digit_buf_t  frame_old;
    int          frame_old_len;
    digit_buf_t  frame_new;
    int          frame_new_len;
    bit          word_ignored;

    out_word_t   pending_results[$];
    int          error_count;
    int          result_count;
    int          useful_words;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_len;
    int          hold_ask;
    int          hold_seen;
    int          hold_count;

    password_lock_controller #(
        .MAX_DIGITS(DIGIT_CAP)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("password_lock_controller_tb NOT OK");
        $finish;
    end

    function automatic void clear_lock_state();
        lock_open_q   = 1'b0;
        password_q    = '0;
        for (int i = 0; i < 4; i++)
            password_q[i] = CH_ZERO;
        password_len  = 4;
        entry_q       = '0;
        entry_len     = 0;
        frame_phase   = LINK_IDLE;
        frame_old     = '0;
        frame_old_len = 0;
        frame_new     = '0;
        frame_new_len = 0;
    endfunction

    // Lengths must agree; an empty password matches an empty entry.
    function automatic bit password_equal(input digit_buf_t cand, input int len);
        if (len != password_len || len > DIGIT_CAP)
            return 1'b0;
        for (int i = 0; i < len; i++)
            if (cand[i] !== password_q[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void install_password(input digit_buf_t src, input int len);
        password_q = '0;
        for (int i = 0; i < len; i++)
            password_q[i] = src[i];
        password_len = len;
    endfunction

    function automatic out_word_t predict_lock(input in_word_t w);
        out_word_t   r;
        logic [2:0]  ev;
        logic [7:0]  s;
        s = w.symbol;
        ev = EV_NONE;
        r = '0;
        word_ignored = 1'b0;
        if (w.kind == KIND_KEYPAD)
        begin
            if (s == CH_Y)
            begin
                if (lock_open_q)
                begin
                    install_password(entry_q, entry_len);
                    lock_open_q = 1'b0;
                    ev = EV_KEYCHG;
                end
                else if (password_equal(entry_q, entry_len))
                begin
                    lock_open_q = 1'b1;
                    ev = EV_UNLOCK;
                end
                else
                begin
                    ev = EV_WRONG;
                end
                entry_len = 0;
            end
            else if (s == CH_N)
            begin
                lock_open_q = 1'b0;
                entry_len = 0;
                ev = EV_CANCEL;
            end
            else if (s >= CH_ZERO && s <= CH_NINE)
            begin
                // A digit on a full entry starts the entry over.
                if (entry_len >= DIGIT_CAP)
                begin
                    entry_len = 0;
                    r.entry_wrapped = 1'b1;
                end
                entry_q[entry_len] = s;
                entry_len++;
                r.echo_char = s;
                ev = EV_DIGIT;
            end
            else
            begin
                word_ignored = 1'b1;
            end
        end
        else if (frame_phase == LINK_OLD || frame_phase == LINK_NEW)
        begin
            if (s == CH_E)
            begin
                ev = EV_REFUSED;
                if (frame_phase == LINK_NEW && password_equal(frame_old, frame_old_len))
                begin
                    install_password(frame_new, frame_new_len);
                    ev = EV_REMCHG;
                end
                frame_phase = LINK_IDLE;
            end
            else if (s == CH_R)
            begin
                frame_phase = (frame_phase == LINK_OLD) ? LINK_NEW : LINK_IDLE;
            end
            else if (frame_phase == LINK_OLD)
            begin
                if (frame_old_len < DIGIT_CAP)
                begin
                    frame_old[frame_old_len] = s;
                    frame_old_len++;
                end
            end
            else if (frame_new_len < DIGIT_CAP)
            begin
                frame_new[frame_new_len] = s;
                frame_new_len++;
            end
        end
        else if (s == CH_C)
        begin
            frame_phase   = LINK_OLD;
            frame_old     = '0;
            frame_old_len = 0;
            frame_new     = '0;
            frame_new_len = 0;
        end
        else
        begin
            frame_phase = LINK_IDLE;
            word_ignored = 1'b1;
        end
        r.door_open      = lock_open_q;
        r.event_res      = ev;
        r.digits_entered = 4'(entry_len);
        return r;
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            note_failure($sformatf("result %0d, %s: got %0h, expected %0h",
                                   result_count, name, got, want));
    endtask

    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                note_failure($sformatf("result %0d arrived with nothing expected", result_count));
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("door_open", out_word.door_open, want.door_open);
                check_field("event_res", out_word.event_res, want.event_res);
                check_field("echo_char", out_word.echo_char, want.echo_char);
                check_field("entry_wrapped", out_word.entry_wrapped, want.entry_wrapped);
                check_field("digits_entered", out_word.digits_entered, want.digits_entered);
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when a test asks for one.
    always @(posedge clk)
    begin
        if (hold_ask != hold_seen)
        begin
            hold_seen = hold_ask;
            hold_count = hold_len;
        end
        if (hold_count > 0)
        begin
            hold_count--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_word(input logic kind, input logic [7:0] sym);
        in_word_t w;
        w.kind = kind;
        w.symbol = sym;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_results.push_back(predict_lock(w));
        if (!word_ignored)
            useful_words++;
    endtask

    // Link byte, now and then preceded by a keypad word that leaves the password alone.
    task automatic send_link(input logic [7:0] sym);
        if ($urandom_range(99) < 8)
            send_word(KIND_KEYPAD, ($urandom_range(1) == 0) ? CH_N : CH_ZERO + 8'($urandom_range(9)));
        send_word(KIND_LINK, sym);
    endtask

    function automatic logic [7:0] frame_byte();
        logic [7:0] b;
        if ($urandom_range(9) == 0)
            return CH_C;
        do
            b = 8'($urandom_range(255));
        while (b == CH_E || b == CH_R);
        return b;
    endfunction

    task automatic test_keypad();
        send_word(KIND_KEYPAD, 8'h00);
        send_word(KIND_KEYPAD, 8'hFF);
        send_word(KIND_KEYPAD, CH_Y);
        repeat (4) send_word(KIND_KEYPAD, CH_ZERO);
        send_word(KIND_KEYPAD, CH_Y);
        // Enter on an empty entry while open installs an empty password.
        send_word(KIND_KEYPAD, CH_Y);
        send_word(KIND_KEYPAD, CH_Y);
        repeat (DIGIT_CAP + 1) send_word(KIND_KEYPAD, CH_NINE);
        send_word(KIND_KEYPAD, CH_Y);
        send_word(KIND_KEYPAD, CH_NINE);
        send_word(KIND_KEYPAD, CH_N);
    endtask

    task automatic test_link();
        send_word(KIND_LINK, 8'h00);
        send_word(KIND_LINK, 8'hFF);
        send_word(KIND_LINK, CH_C);
        send_word(KIND_LINK, CH_E);
        send_word(KIND_LINK, CH_C);
        send_word(KIND_LINK, CH_NINE);
        send_word(KIND_LINK, CH_R);
        send_word(KIND_LINK, CH_R);
        // A 'C' inside the frame is data, and the eleventh new byte is dropped.
        send_word(KIND_LINK, CH_C);
        send_word(KIND_LINK, CH_NINE);
        send_word(KIND_LINK, CH_R);
        for (int i = 0; i <= DIGIT_CAP; i++)
            send_word(KIND_LINK, (i == 3) ? CH_C : CH_ZERO + 8'(i));
        send_word(KIND_LINK, CH_E);
    endtask

    task automatic keypad_session();
        int n;
        if (!lock_open_q && $urandom_range(99) < 60)
        begin
            for (int i = 0; i < password_len; i++)
                send_word(KIND_KEYPAD, password_q[i]);
            send_word(KIND_KEYPAD, CH_Y);
        end
        else
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, DIGIT_CAP);
            repeat (n) send_word(KIND_KEYPAD, CH_ZERO + 8'($urandom_range(9)));
            send_word(KIND_KEYPAD, ($urandom_range(99) < 80) ? CH_Y : CH_N);
        end
    endtask

    task automatic link_frame();
        int n;
        int pick;
        pick = $urandom_range(99);
        send_link(CH_C);
        if ($urandom_range(99) < 65)
        begin
            for (int i = 0; i < password_len; i++)
                send_link(password_q[i]);
        end
        else
        begin
            n = $urandom_range(0, 12);
            repeat (n) send_link(frame_byte());
        end
        if (pick < 10)
        begin
            send_link(CH_E);
        end
        else
        begin
            send_link(CH_R);
            if (pick < 85)
            begin
                n = $urandom_range(1, DIGIT_CAP);
                repeat (n) send_link(CH_ZERO + 8'($urandom_range(9)));
            end
            else
            begin
                n = $urandom_range(0, 12);
                repeat (n) send_link(frame_byte());
            end
            send_link((pick < 16) ? CH_R : CH_E);
        end
    endtask

    task automatic test_random(input int target);
        int goal;
        int pick;
        int n;
        logic [7:0] sym;
        goal = useful_words + target;
        while (useful_words < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                keypad_session();
            end
            else if (pick < 70)
            begin
                link_frame();
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    case ($urandom_range(9))
                        0: sym = CH_Y;
                        1: sym = CH_N;
                        2: sym = CH_C;
                        3: sym = CH_E;
                        4: sym = CH_R;
                        5: sym = CH_ZERO + 8'($urandom_range(9));
                        default: sym = 8'($urandom_range(255));
                    endcase
                    send_word(1'($urandom_range(1)), sym);
                end
            end
        end
    endtask

    // The receiver holds off while digits keep coming, so the block must stall its input.
    task automatic test_backpressure();
        hold_len = 200;
        hold_ask++;
        repeat (12) send_word(KIND_KEYPAD, CH_ZERO + 8'($urandom_range(9)));
        send_word(KIND_KEYPAD, CH_N);
    endtask

    initial
    begin
        in_valid       = 1'b0;
        in_word        = '0;
        out_stall      = 1'b0;
        rst_n          = 1'b0;
        error_count    = 0;
        result_count   = 0;
        useful_words   = 0;
        hold_len       = 0;
        hold_ask       = 0;
        hold_seen      = 0;
        hold_count     = 0;
        send_idle_pct  = 28;
        recv_stall_pct = 72;
        clear_lock_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_keypad();
        test_link();
        test_random(180);
        send_idle_pct  = 72;
        recv_stall_pct = 28;
        test_random(180);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_backpressure();
        test_random(190);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("password_lock_controller_tb OK");
        else
            $display("password_lock_controller_tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
hdl/plc_pkg.sv
hdl/plc_ctrl.sv
hdl/plc_datapath.sv
hdl/password_lock_controller.sv
tb/password_lock_controller_tb.sv
